FILE: rtl/core/toroidal_grid_diffusion_decay_defines.svh
// Assertion macros for the RTL, used by toroidal_grid_diffusion_decay.sv.
`ifndef TOROIDAL_GRID_DIFFUSION_DECAY_DEFINES_SVH
`define TOROIDAL_GRID_DIFFUSION_DECAY_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TGDD_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define TGDD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/tgdd_pkg.sv
`default_nettype none
package tgdd_pkg;
    localparam int MaxWidth    = 64;
    localparam int MaxHeight   = 64;
    localparam int MaxFactions = 4;
    localparam int CellBits    = 16;

    localparam int XW          = $clog2(MaxWidth);
    localparam int YW          = $clog2(MaxHeight);
    localparam int PW          = $clog2(2 * MaxFactions);
    localparam int BufAw       = XW + YW;
    localparam int StoreAw     = PW + BufAw;
    localparam int BufDepth    = MaxWidth * MaxHeight;
    localparam int StoreDepth  = 2 * MaxFactions * BufDepth;
    localparam int AccW        = CellBits + 5;

    localparam int InDataW     = 72;
    localparam int OutDataW    = 24;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_STEP  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        CFG_WIDTH   = 3'd0,
        CFG_HEIGHT  = 3'd1,
        CFG_FACTION = 3'd2,
        CFG_SHIFT   = 3'd3,
        CFG_PERIOD  = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_DIV,
        ST_CELL,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_DECAY_RD,
        ST_DECAY_WR
    } state_t;

    function automatic logic [CellBits-1:0] share_of(input logic [CellBits-1:0] v,
                                                      input logic [3:0] shift);
        logic [CellBits-1:0] s;
        s = v >> shift;
        return s >> 3;
    endfunction
endpackage
`default_nettype wire

FILE: rtl/core/toroidal_grid_diffusion_decay.sv
// Write command: result registered in the cycle after the transaction, one write per cycle while m_tready is high.
// Read command: cell store read, then ST_RD_WAIT, then the registered result; no new command until ST_IDLE.
// Day step: the day remainder first, then for each plane in use, nine cell store reads and a
// buffer write per cell in use, then a copy of the plane back from the buffer, then, when decay
// applies, every cell of the store is halved.
// aresetn is synchronous and active low; registers reset to 64, 64, 4, 2, 0.
`default_nettype none
`include "toroidal_grid_diffusion_decay_defines.svh"
module toroidal_grid_diffusion_decay (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // cmd, plane_select, cell_x, cell_y, cell_value, day
    input  wire logic [tgdd_pkg::InDataW-1:0]  s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // read_value, decay_applied
    output logic      [tgdd_pkg::OutDataW-1:0] m_tdata,
    input  wire logic                          cfg_wr_en,
    input  wire logic [2:0]                    cfg_index,
    input  wire logic [15:0]                   cfg_wdata
);
    import tgdd_pkg::*;

    logic [6:0]  width_reg, height_reg;
    logic [2:0]  faction_reg;
    logic [3:0]  shift_reg;
    logic [15:0] period_reg;

    state_t              state_reg, state_next;
    logic [3:0]          k_reg, k_next;
    logic [XW-1:0]       x_reg, x_next;
    logic [YW-1:0]       y_reg, y_next;
    logic [PW-1:0]       plane_reg, plane_next;
    logic signed [AccW-1:0] acc_reg, acc_next;
    logic [31:0]         day_reg, day_next;
    logic [StoreAw-1:0]  daddr_reg, daddr_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [CellBits-1:0] rv_reg, rv_next;
    logic                dec_reg, dec_next;

    logic [1:0]          in_cmd;
    logic [PW-1:0]       in_plane;
    logic [XW-1:0]       in_x;
    logic [YW-1:0]       in_y;
    logic [CellBits-1:0] in_value;
    logic [31:0]         in_day;

    logic [6:0] w_eff, h_eff;
    logic [2:0] f_eff;
    logic       last_x, last_y, last_plane, sizes_ok, decay_ok;
    logic [XW-1:0] xl, xr, nx;
    logic [YW-1:0] yu, yd, ny;

    logic                st_we;
    logic [StoreAw-1:0]  st_waddr, st_raddr;
    logic [CellBits-1:0] st_wdata, st_rdata;
    logic                bf_we;
    logic [BufAw-1:0]    bf_waddr, bf_raddr;
    logic [CellBits-1:0] bf_wdata, bf_rdata;

    logic                rem_start;
    logic                rem_busy;
    logic [15:0]         rem_value;
    logic signed [AccW-1:0] term;
    logic [CellBits-1:0] sh;
    logic                accept;

    assign in_cmd   = s_tdata[1:0];
    assign in_plane = s_tdata[4:2];
    assign in_x     = s_tdata[10:5];
    assign in_y     = s_tdata[16:11];
    assign in_value = s_tdata[32:17];
    assign in_day   = s_tdata[64:33];

    assign w_eff = (width_reg > 7'(MaxWidth)) ? 7'(MaxWidth) : width_reg;
    assign h_eff = (height_reg > 7'(MaxHeight)) ? 7'(MaxHeight) : height_reg;
    assign f_eff = (faction_reg > 3'(MaxFactions)) ? 3'(MaxFactions) : faction_reg;
    assign sizes_ok = (w_eff != '0) && (h_eff != '0) && (f_eff != '0);

    assign last_x     = ({1'b0, x_reg} == w_eff - 7'd1);
    assign last_y     = ({1'b0, y_reg} == h_eff - 7'd1);
    assign last_plane = ({1'b0, plane_reg} == {f_eff, 1'b0} - 4'd1);
    assign xl = (x_reg == '0) ? XW'(w_eff - 7'd1) : x_reg - XW'(1);
    assign xr = last_x ? '0 : x_reg + XW'(1);
    assign yu = (y_reg == '0) ? YW'(h_eff - 7'd1) : y_reg - YW'(1);
    assign yd = last_y ? '0 : y_reg + YW'(1);
    assign nx = last_x ? '0 : x_reg + XW'(1);
    assign ny = last_y ? '0 : y_reg + YW'(1);

    assign decay_ok = (period_reg != '0) && (day_reg != '0) && !day_reg[31]
                      && (rem_value == '0);

    assign s_tready = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, dec_reg, rv_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= 7'd64;
            height_reg  <= 7'd64;
            faction_reg <= 3'd4;
            shift_reg   <= 4'd2;
            period_reg  <= 16'd0;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_WIDTH:   width_reg   <= cfg_wdata[6:0];
                CFG_HEIGHT:  height_reg  <= cfg_wdata[6:0];
                CFG_FACTION: faction_reg <= cfg_wdata[2:0];
                CFG_SHIFT:   shift_reg   <= cfg_wdata[3:0];
                CFG_PERIOD:  period_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        k_reg     <= k_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        plane_reg <= plane_next;
        acc_reg   <= acc_next;
        day_reg   <= day_next;
        daddr_reg <= daddr_next;
        rv_reg    <= rv_next;
        dec_reg   <= dec_next;
    end

    // Accumulator term for the data that returns this cycle: the center when k is one.
    always_comb begin
        sh = share_of(st_rdata, shift_reg);
        if (k_reg == 4'd1) begin
            term = AccW'({1'b0, st_rdata}) - AccW'({1'b0, sh, 3'b000});
        end else begin
            term = AccW'({1'b0, sh});
        end
    end

    always_comb begin
        state_next    = state_reg;
        k_next        = k_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        plane_next    = plane_reg;
        acc_next      = acc_reg;
        day_next      = day_reg;
        daddr_next    = daddr_reg;
        rv_next       = rv_reg;
        dec_next      = dec_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        st_we         = 1'b0;
        st_waddr      = {plane_reg, y_reg, x_reg};
        st_wdata      = bf_rdata;
        st_raddr      = {plane_reg, y_reg, x_reg};
        bf_we         = 1'b0;
        bf_waddr      = {y_reg, x_reg};
        bf_wdata      = '0;
        bf_raddr      = {y_reg, x_reg};
        rem_start     = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                st_raddr = {in_plane, in_y, in_x};
                if (accept) begin
                    case (cmd_t'(in_cmd))
                        CMD_WRITE: begin
                            st_we         = 1'b1;
                            st_waddr      = {in_plane, in_y, in_x};
                            st_wdata      = in_value;
                            m_tvalid_next = 1'b1;
                            rv_next       = '0;
                            dec_next      = 1'b0;
                        end
                        CMD_READ: begin
                            state_next = ST_RD_WAIT;
                        end
                        CMD_STEP: begin
                            day_next   = in_day;
                            rem_start  = 1'b1;
                            x_next     = '0;
                            y_next     = '0;
                            plane_next = '0;
                            k_next     = '0;
                            if (sizes_ok) begin
                                state_next = ST_DIV;
                            end else begin
                                m_tvalid_next = 1'b1;
                                rv_next       = '0;
                                dec_next      = 1'b0;
                            end
                        end
                        default: begin
                            m_tvalid_next = 1'b1;
                            rv_next       = '0;
                            dec_next      = 1'b0;
                        end
                    endcase
                end
            end
            ST_RD_WAIT: begin
                m_tvalid_next = 1'b1;
                rv_next       = st_rdata;
                dec_next      = 1'b0;
                state_next    = ST_IDLE;
            end
            ST_DIV: begin
                if (!rem_busy) begin
                    state_next = ST_CELL;
                end
            end
            ST_CELL: begin
                case (k_reg)
                    4'd0:    st_raddr = {plane_reg, y_reg, x_reg};
                    4'd1:    st_raddr = {plane_reg, yu, xl};
                    4'd2:    st_raddr = {plane_reg, yu, x_reg};
                    4'd3:    st_raddr = {plane_reg, yu, xr};
                    4'd4:    st_raddr = {plane_reg, y_reg, xl};
                    4'd5:    st_raddr = {plane_reg, y_reg, xr};
                    4'd6:    st_raddr = {plane_reg, yd, xl};
                    4'd7:    st_raddr = {plane_reg, yd, x_reg};
                    4'd8:    st_raddr = {plane_reg, yd, xr};
                    default: st_raddr = {plane_reg, y_reg, x_reg};
                endcase
                if (k_reg == 4'd1) begin
                    acc_next = term;
                end else if (k_reg != 4'd0) begin
                    acc_next = acc_reg + term;
                end
                k_next = k_reg + 4'd1;
                if (k_reg == 4'd9) begin
                    k_next = '0;
                    bf_we  = 1'b1;
                    if (acc_next < 0) begin
                        bf_wdata = '0;
                    end else if (acc_next > AccW'({1'b0, {CellBits{1'b1}}})) begin
                        bf_wdata = '1;
                    end else begin
                        bf_wdata = acc_next[CellBits-1:0];
                    end
                    x_next = nx;
                    if (last_x) begin
                        y_next = ny;
                        if (last_y) begin
                            state_next = ST_COPY_RD;
                        end
                    end
                end
            end
            ST_COPY_RD: begin
                state_next = ST_COPY_WR;
            end
            ST_COPY_WR: begin
                st_we      = 1'b1;
                x_next     = nx;
                state_next = ST_COPY_RD;
                if (last_x) begin
                    y_next = ny;
                    if (last_y) begin
                        if (!last_plane) begin
                            plane_next = plane_reg + PW'(1);
                            state_next = ST_CELL;
                        end else if (decay_ok) begin
                            daddr_next = '0;
                            state_next = ST_DECAY_RD;
                        end else begin
                            m_tvalid_next = 1'b1;
                            rv_next       = '0;
                            dec_next      = 1'b0;
                            state_next    = ST_IDLE;
                        end
                    end
                end
            end
            ST_DECAY_RD: begin
                st_raddr   = daddr_reg;
                state_next = ST_DECAY_WR;
            end
            ST_DECAY_WR: begin
                st_we      = 1'b1;
                st_waddr   = daddr_reg;
                st_wdata   = st_rdata >> 1;
                daddr_next = daddr_reg + StoreAw'(1);
                state_next = ST_DECAY_RD;
                if (daddr_reg == '1) begin
                    m_tvalid_next = 1'b1;
                    rv_next       = '0;
                    dec_next      = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    tgdd_ram #(.Width(CellBits), .Depth(StoreDepth)) u_store (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    tgdd_ram #(.Width(CellBits), .Depth(BufDepth)) u_buf (
        .aclk  (aclk),
        .we    (bf_we),
        .waddr (bf_waddr),
        .wdata (bf_wdata),
        .raddr (bf_raddr),
        .rdata (bf_rdata)
    );

    tgdd_rem u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (rem_start),
        .dividend  (day_next),
        .divisor   (period_reg),
        .busy      (rem_busy),
        .remainder (rem_value)
    );

    `TGDD_ASSERT_SAME(a_ready_idle, aclk, aresetn, s_tready, state_reg == ST_IDLE,
        "input taken outside idle")
    `TGDD_ASSERT_SAME(a_cell_after_rem, aclk, aresetn, state_reg == ST_CELL, !rem_busy,
        "diffusion started before the day remainder was ready")
    `TGDD_ASSERT_SAME(a_decay_no_read, aclk, aresetn, m_tvalid_reg && dec_reg, rv_reg == '0,
        "decay result carries a read value")
    `TGDD_ASSERT_NEXT(a_read_wait, aclk, aresetn, state_reg == ST_RD_WAIT,
        m_tvalid_reg && state_reg == ST_IDLE, "read result not delivered")
endmodule
`default_nettype wire

FILE: rtl/core/tgdd_ram.sv
`default_nettype none
module tgdd_ram #(
    parameter int Width = 16,
    parameter int Depth = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/core/tgdd_rem.sv
`default_nettype none
module tgdd_rem (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [31:0]       dividend,
    input  wire logic [15:0]       divisor,
    output logic                   busy,
    output logic      [15:0]       remainder
);
    import tgdd_pkg::*;

    logic        busy_reg, busy_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] dvd_reg, dvd_next;
    logic [15:0] rem_reg, rem_next;
    logic [16:0] trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    // One restoring step per cycle, most significant dividend bit first.
    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dvd_reg[31]};
        if (trial >= {1'b0, divisor}) begin
            trial = trial - {1'b0, divisor};
        end
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            rem_next  = '0;
        end else if (busy_reg) begin
            rem_next  = trial[15:0];
            dvd_next  = {dvd_reg[30:0], 1'b0};
            cnt_next  = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
            end
        end
    end

    assign busy      = busy_reg;
    assign remainder = rem_reg;
endmodule
`default_nettype wire

FILE: test/grid_checker.sv
module grid_checker
    import tgdd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [InDataW-1:0]   s_tdata,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [OutDataW-1:0]  m_tdata,
    input  wire logic                 cfg_wr_en,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [15:0]          cfg_wdata,
    output int                        mismatches,
    output int                        pending,
    output int                        checked
);
    typedef struct packed {
        logic [15:0] read_value;
        logic        decay_applied;
    } grid_result_t;

    logic [15:0] cells [StoreDepth];
    logic [15:0] next_cells [BufDepth];
    logic [6:0]  grid_w;
    logic [6:0]  grid_h;
    logic [2:0]  factions;
    logic [3:0]  shift;
    logic [15:0] period;
    grid_result_t awaited_q[$];

    initial begin
        mismatches = 0;
        pending = 0;
        checked = 0;
    end

    function automatic int gift(logic [15:0] v);
        return int'((v >> shift) >> 3);
    endfunction

    function automatic void spread_plane(int pl, int w, int h);
        int base;
        int x;
        int y;
        int xl;
        int xr;
        int yu;
        int yd;
        int acc;
        base = pl * BufDepth;
        for (y = 0; y < h; y++) begin
            yu = (y == 0) ? h - 1 : y - 1;
            yd = (y == h - 1) ? 0 : y + 1;
            for (x = 0; x < w; x++) begin
                xl = (x == 0) ? w - 1 : x - 1;
                xr = (x == w - 1) ? 0 : x + 1;
                acc = int'(cells[base + y * MaxWidth + x]);
                acc -= 8 * gift(cells[base + y * MaxWidth + x]);
                acc += gift(cells[base + yu * MaxWidth + xl]);
                acc += gift(cells[base + yu * MaxWidth + x]);
                acc += gift(cells[base + yu * MaxWidth + xr]);
                acc += gift(cells[base + y * MaxWidth + xl]);
                acc += gift(cells[base + y * MaxWidth + xr]);
                acc += gift(cells[base + yd * MaxWidth + xl]);
                acc += gift(cells[base + yd * MaxWidth + x]);
                acc += gift(cells[base + yd * MaxWidth + xr]);
                if (acc < 0) acc = 0;
                if (acc > 65535) acc = 65535;
                next_cells[y * MaxWidth + x] = acc[15:0];
            end
        end
        for (y = 0; y < h; y++)
            for (x = 0; x < w; x++)
                cells[base + y * MaxWidth + x] = next_cells[y * MaxWidth + x];
    endfunction

    function automatic grid_result_t apply_command(logic [InDataW-1:0] d);
        cmd_t         c;
        int           addr;
        logic [31:0]  dy;
        int           w;
        int           h;
        int           f;
        int           i;
        grid_result_t r;
        c = cmd_t'(d[1:0]);
        addr = int'({d[4:2], d[16:11], d[10:5]});
        dy = d[64:33];
        r = '0;
        case (c)
            CMD_WRITE: cells[addr] = d[32:17];
            CMD_READ:  r.read_value = cells[addr];
            CMD_STEP: begin
                w = (grid_w > MaxWidth) ? MaxWidth : int'(grid_w);
                h = (grid_h > MaxHeight) ? MaxHeight : int'(grid_h);
                f = (factions > MaxFactions) ? MaxFactions : int'(factions);
                if (w != 0 && h != 0 && f != 0) begin
                    for (i = 0; i < 2 * f; i++) spread_plane(i, w, h);
                    if (period != 0 && dy != 0 && !dy[31] && dy % period == 0) begin
                        for (i = 0; i < StoreDepth; i++) cells[i] = cells[i] >> 1;
                        r.decay_applied = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            grid_w = 7'd64;
            grid_h = 7'd64;
            factions = 3'd4;
            shift = 4'd2;
            period = 16'd0;
            awaited_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_WIDTH:   grid_w = cfg_wdata[6:0];
                    CFG_HEIGHT:  grid_h = cfg_wdata[6:0];
                    CFG_FACTION: factions = cfg_wdata[2:0];
                    CFG_SHIFT:   shift = cfg_wdata[3:0];
                    CFG_PERIOD:  period = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (awaited_q.size() == 0) begin
                    $error("result transaction with no command outstanding");
                    mismatches++;
                end else begin
                    grid_result_t e;
                    e = awaited_q.pop_front();
                    checked++;
                    if (m_tdata[15:0] !== e.read_value) begin
                        $error("read_value: expected %h, got %h", e.read_value, m_tdata[15:0]);
                        mismatches++;
                    end
                    if (m_tdata[16] !== e.decay_applied) begin
                        $error("decay_applied: expected %b, got %b",
                               e.decay_applied, m_tdata[16]);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) awaited_q.push_back(apply_command(s_tdata));
        end
        pending = awaited_q.size();
    end
endmodule

FILE: test/tb.sv
module tb;
    import tgdd_pkg::*;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [InDataW-1:0]   s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OutDataW-1:0]  m_tdata;
    logic                 cfg_wr_en = 1'b0;
    logic [2:0]           cfg_index = '0;
    logic [15:0]          cfg_wdata = '0;
    int                   mismatches;
    int                   pending;
    int                   checked;

    int idle_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int commands = 0;
    int day_steps = 0;
    int configs = 0;
    bit written [StoreDepth];
    int written_q[$];

    toroidal_grid_diffusion_decay dut (.*);

    grid_checker checker_i (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial forever begin
        @(posedge aclk);
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin
        #60000000;
        $display("toroidal_grid_diffusion_decay: mismatch");
        $finish;
    end

    task automatic send(cmd_t c, logic [2:0] p, logic [5:0] x, logic [5:0] y,
                        logic [15:0] v, logic [31:0] d);
        int addr;
        addr = int'({p, y, x});
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, d, v, y, x, p, c};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        commands++;
        if (c == CMD_STEP) day_steps++;
        if (c == CMD_WRITE && !written[addr]) begin
            written[addr] = 1'b1;
            written_q.push_back(addr);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (pending == 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic configure(int w, int h, int f, int sh, int per);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_WIDTH;   cfg_wdata <= 16'(w);   @(posedge aclk);
        cfg_index <= CFG_HEIGHT;  cfg_wdata <= 16'(h);   @(posedge aclk);
        cfg_index <= CFG_FACTION; cfg_wdata <= 16'(f);   @(posedge aclk);
        cfg_index <= CFG_SHIFT;   cfg_wdata <= 16'(sh);  @(posedge aclk);
        cfg_index <= CFG_PERIOD;  cfg_wdata <= 16'(per); @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        configs++;
        // Every cell that the diffusion of a step will touch gets a defined value first.
        for (int p = 0; p < 2 * ((f > 4) ? 4 : f); p++)
            for (int y = 0; y < ((h > 64) ? 64 : h); y++)
                for (int x = 0; x < ((w > 64) ? 64 : w); x++)
                    send(CMD_WRITE, 3'(p), 6'(x), 6'(y), 16'($urandom), $urandom);
    endtask

    task automatic read_written();
        int a;
        a = written_q[$urandom_range(written_q.size() - 1)];
        send(CMD_READ, a[14:12], a[5:0], a[11:6], 16'($urandom), $urandom);
    endtask

    task automatic step(logic [31:0] d);
        send(CMD_STEP, 3'($urandom), 6'($urandom), 6'($urandom), 16'($urandom), d);
    endtask

    initial begin
        int seg;
        int sel;
        int per;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        configure(64, 1, 1, 0, 0);
        read_written();
        step(32'd0);
        read_written();
        configure(127, 1, 1, 15, 1);
        step(32'd7);
        read_written();
        configure(1, 64, 1, 2, 65535);
        step(32'd65535);
        step(32'h8000_0000);
        step(32'd0);
        read_written();
        configure(2, 2, 4, 3, 1);
        step(32'hFFFF_FFFF);
        step(32'd1);
        read_written();
        configure(0, 2, 1, 2, 1);
        step(32'd1);
        configure(2, 0, 1, 2, 1);
        step(32'd1);
        configure(2, 2, 0, 2, 1);
        step(32'd1);
        configure(2, 2, 7, 1, 0);
        step(32'd3);
        send(CMD_WRITE, 3'd7, 6'd63, 6'd63, 16'hFFFF, 32'hFFFF_FFFF);
        send(CMD_READ, 3'd7, 6'd63, 6'd63, 16'd0, 32'd0);
        send(CMD_WRITE, 3'd7, 6'd63, 6'd63, 16'd0, 32'd0);
        send(CMD_READ, 3'd7, 6'd63, 6'd63, 16'hFFFF, 32'hFFFF_FFFF);
        send(CMD_NONE, 3'd7, 6'd63, 6'd63, 16'hFFFF, 32'hFFFF_FFFF);
        send(CMD_NONE, 3'd0, 6'd0, 6'd0, 16'd0, 32'd0);

        drain();
        hold_left = 300;
        repeat (30) read_written();
        step(32'd2);

        seg = 0;
        while (commands < 1300) begin
            case (seg % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 56; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 56; end
                default: begin idle_pct = 22; stall_pct = 22; end
            endcase
            sel = $urandom_range(2);
            per = (sel == 0) ? 0 : (sel == 1) ? 65535 : $urandom_range(1000, 65535);
            configure(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4),
                      ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4),
                      ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4),
                      $urandom_range(15), per);
            repeat ($urandom_range(30, 60)) begin
                sel = $urandom_range(99);
                if (sel < 45)
                    send(CMD_WRITE, 3'($urandom), 6'($urandom), 6'($urandom),
                         16'($urandom), $urandom);
                else if (sel < 87)
                    read_written();
                else if (sel < 97)
                    step($urandom);
                else
                    send(CMD_NONE, 3'($urandom), 6'($urandom), 6'($urandom),
                         16'($urandom), $urandom);
            end
            seg++;
        end

        drain();
        repeat (20) @(posedge aclk);
        $display("Run covered %0d commands, %0d day steps and %0d register settings.",
                 commands, day_steps, configs);
        $display("%0d results were compared against the prediction.", checked);
        if (mismatches == 0) begin
            $display("toroidal_grid_diffusion_decay: match");
        end else begin
            $display("toroidal_grid_diffusion_decay: mismatch");
        end
        $finish;
    end
endmodule
